[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked check, disabled while reset is asserted
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check, active during reset too
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/swfr_pkg.sv]
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared types and constants of the stop-and-wait frame receiver.
// ----------------------------------------------------------------------------
package swfr_pkg;

  localparam int unsigned FRAME_DEPTH = 64;

  localparam logic [7:0] POLY_RESET = 8'h07;
  localparam logic [7:0] CRC_MSB    = 8'h80;

  // "FIN"
  localparam logic [7:0] FIN_F = 8'h46;
  localparam logic [7:0] FIN_I = 8'h49;
  localparam logic [7:0] FIN_N = 8'h4E;

  localparam logic RK_PAYLOAD = 1'b0;
  localparam logic RK_ACK     = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] ack_seq;
    logic       from_name_frame;
    logic       end_of_transfer;
    logic       last_of_run;
  } out_t;

  // expected character of "FIN" after p matched characters
  function automatic logic [7:0] fin_char(logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = FIN_F;
      2'd1:    c = FIN_I;
      2'd2:    c = FIN_N;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/swfr_crc.sv]
// ----------------------------------------------------------------------------
// swfr_crc
// Folds one byte into the 8-bit CRC remainder, MSB first.
// ----------------------------------------------------------------------------
module swfr_crc (
  input  logic [7:0] rem_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] poly_i,
  output logic [7:0] rem_o
);

  always_comb begin
    logic [7:0] r;
    r = rem_i ^ byte_i;
    for (int k = 0; k < 8; k++) begin
      if ((r & swfr_pkg::CRC_MSB) != 8'h00) begin
        r = r ^ poly_i;
      end
      r = {r[6:0], 1'b0};
    end
    rem_o = r;
  end

endmodule

[rtl/swfr_store.sv]
// ----------------------------------------------------------------------------
// swfr_store
// Frame byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module swfr_store #(
  parameter int unsigned Depth = swfr_pkg::FRAME_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/stop_and_wait_frame_receiver.sv]
// ----------------------------------------------------------------------------
// stop_and_wait_frame_receiver
// Checks CRC-8 framed bytes and replays good frames as payload words + ack.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_word_i): one frame byte per
// word, frame_end set on the sequence byte. The byte before it is the CRC.
// Output channel (out_valid_o / out_stall_i / out_word_o): result words;
// each good frame yields its bytes before the CRC, then one acknowledgement
// with last_of_run set. The first good frame is the file name frame; a later
// good frame holding "FIN" yields only an ack with end_of_transfer set, after
// which all input is taken and ignored until reset.
// Throughput: bytes before the frame end are taken one per cycle. After a
// good frame end the input stalls while the frame is replayed from the
// store: a store read, then an output load for each payload word, then the
// ack. The output register holds a stalled word; the replay waits on it.
// Order: after the frame end is taken, the first result word is loaded in
// S_LOAD after S_FETCH; a frame that yields only an ack goes to S_ACK.
// Configuration: cfg_we_i writes crc_poly (reset 8'h07); the user writes it
// only while idle, and the block itself does not enforce this.
// Reset clears all control state; the store needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stop_and_wait_frame_receiver #(
  parameter int unsigned FRAME_DEPTH = swfr_pkg::FRAME_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  swfr_pkg::in_t   in_word_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output swfr_pkg::out_t  out_word_o
);

  localparam int unsigned AW = $clog2(FRAME_DEPTH);
  // store holds at most FRAME_DEPTH-1 bytes; the sequence byte is not kept
  localparam logic [AW-1:0] LAST_SLOT = AW'(FRAME_DEPTH - 1);

  // transfer phase
  typedef enum logic [2:0] {
    PH_NAME = 3'b001,
    PH_DATA = 3'b010,
    PH_DONE = 3'b100
  } phase_e;

  // replay sequencer
  typedef enum logic [3:0] {
    S_RECV  = 4'b0001,
    S_FETCH = 4'b0010,
    S_LOAD  = 4'b0100,
    S_ACK   = 4'b1000
  } seq_e;

  seq_e           st_q, st_d;
  phase_e         phase_q, phase_d;
  logic [7:0]     poly_q;
  logic [7:0]     crc_q, crc_d, crc_fold;
  logic [AW-1:0]  cnt_q, cnt_d;
  logic           ovf_q, ovf_d;
  logic [1:0]     finp_q, finp_d;
  logic           fin_q, fin_d;
  logic           zero_q, zero_d;
  logic [7:0]     seq_q, seq_d;
  logic           name_q, name_d;
  logic           eot_q, eot_d;
  logic [AW-1:0]  pay_q, pay_d;
  logic [AW-1:0]  rd_idx_q, rd_idx_d;
  logic           out_valid_q, out_valid_d;
  swfr_pkg::out_t out_q, out_d;

  // FIN scan result for the incoming byte
  logic [1:0]     finp_n;
  logic           fin_n, zero_n;

  logic           acc, active, out_free, good;
  logic           mem_we, mem_re;
  logic [7:0]     rd_data;

  assign in_stall_o  = (st_q != S_RECV);
  assign acc         = in_valid_i && !in_stall_o;
  assign active      = (phase_q == PH_NAME) || (phase_q == PH_DATA);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  swfr_crc u_crc (
    .rem_i  (crc_q),
    .byte_i (in_word_i.frame_byte),
    .poly_i (poly_q),
    .rem_o  (crc_fold)
  );

  swfr_store #(
    .Depth (FRAME_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q),
    .wdata_i (in_word_i.frame_byte),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  // "FIN" search, stops at the first zero byte or at a match
  always_comb begin
    finp_n = finp_q;
    fin_n  = fin_q;
    zero_n = zero_q;
    if (!(zero_q || fin_q)) begin
      if (in_word_i.frame_byte == 8'h00) begin
        zero_n = 1'b1;
      end else if (in_word_i.frame_byte == swfr_pkg::fin_char(finp_q)) begin
        if (finp_q == 2'd2) begin
          fin_n  = 1'b1;
          finp_n = 2'd0;
        end else begin
          finp_n = finp_q + 2'd1;
        end
      end else begin
        finp_n = (in_word_i.frame_byte == swfr_pkg::FIN_F) ? 2'd1 : 2'd0;
      end
    end
  end

  assign good = !ovf_q && (cnt_q != '0) && (crc_q == 8'h00);

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    crc_d       = crc_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    finp_d      = finp_q;
    fin_d       = fin_q;
    zero_d      = zero_q;
    seq_d       = seq_q;
    name_d      = name_q;
    eot_d       = eot_q;
    pay_d       = pay_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    case (st_q)
      S_RECV: begin
        if (acc && active) begin
          finp_d = finp_n;
          fin_d  = fin_n;
          zero_d = zero_n;
          if (!in_word_i.frame_end) begin
            crc_d = crc_fold;
            if (cnt_q < LAST_SLOT) begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            // frame end: clear per-frame state whatever the outcome
            crc_d  = 8'h00;
            cnt_d  = '0;
            ovf_d  = 1'b0;
            finp_d = 2'd0;
            fin_d  = 1'b0;
            zero_d = 1'b0;
            if (good) begin
              seq_d    = in_word_i.frame_byte;
              name_d   = (phase_q == PH_NAME);
              rd_idx_d = '0;
              pay_d    = cnt_q - 1'b1;
              if ((phase_q != PH_NAME) && fin_n) begin
                eot_d = 1'b1;
                st_d  = S_ACK;
              end else begin
                eot_d = 1'b0;
                st_d  = (cnt_q == AW'(1)) ? S_ACK : S_FETCH;
              end
            end
          end
        end
      end
      S_FETCH: begin
        mem_re = 1'b1;
        st_d   = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.result_kind     = swfr_pkg::RK_PAYLOAD;
          out_d.payload_byte    = rd_data;
          out_d.ack_seq         = 8'h00;
          out_d.from_name_frame = name_q;
          out_d.end_of_transfer = 1'b0;
          out_d.last_of_run     = 1'b0;
          rd_idx_d              = rd_idx_q + 1'b1;
          st_d = (AW'(rd_idx_q + 1'b1) == pay_q) ? S_ACK : S_FETCH;
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.result_kind     = swfr_pkg::RK_ACK;
          out_d.payload_byte    = 8'h00;
          out_d.ack_seq         = seq_q;
          out_d.from_name_frame = name_q;
          out_d.end_of_transfer = eot_q;
          out_d.last_of_run     = 1'b1;
          phase_d               = eot_q ? PH_DONE : PH_DATA;
          st_d                  = S_RECV;
        end
      end
      default: begin
        st_d = S_RECV;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_RECV;
      phase_q     <= PH_NAME;
      poly_q      <= swfr_pkg::POLY_RESET;
      crc_q       <= 8'h00;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      finp_q      <= 2'd0;
      fin_q       <= 1'b0;
      zero_q      <= 1'b0;
      eot_q       <= 1'b0;
      pay_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      if (cfg_we_i) begin
        poly_q <= cfg_wdata_i;
      end
      crc_q       <= crc_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      finp_q      <= finp_d;
      fin_q       <= fin_d;
      zero_q      <= zero_d;
      eot_q       <= eot_d;
      pay_q       <= pay_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    name_q <= name_d;
    out_q  <= out_d;
  end

  // store is written only while receiving, read only while replaying
  `ASSERT_RST(a_store_excl, clk_i, rst_ni, !(mem_we && (st_q != S_RECV)), "store write in replay")
  `ASSERT_RST(a_rd_range, clk_i, rst_ni, (st_q == S_FETCH) |-> (rd_idx_q < pay_q), "read past frame")
  `ASSERT_RST(a_done_sticky, clk_i, rst_ni, (phase_q == PH_DONE) |=> (phase_q == PH_DONE), "left done")
  `ASSERT_RST(a_last_is_ack, clk_i, rst_ni,
              out_valid_o |-> (out_word_o.last_of_run == out_word_o.result_kind), "last not ack")

endmodule
